// ===== rtl/bounded_deque_with_search_assert.svh =====
// Assertion macros used by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DQS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dqs_pkg.sv =====
`timescale 1ns / 1ps
package dqs_pkg;

	// Fixed field widths.
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned STATUS_W = 2;

	// Operation codes carried on the mode field.
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

endpackage

// ===== rtl/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// Channel    Handshake                 Payload
// command    start / busy              mode, value
// result     done (one-cycle strobe)   status, found, count
//
// Pushes and pops update the state at the transfer edge; for these, unused codes and a search
// of an empty deque, done strobes in the very next cycle.
// A search of n live entries reads the ring memory one entry per cycle and holds busy
// high until all n have been compared, ending early on a match. Done strobes in the
// cycle busy falls.
// Reset empties the deque at once; the entry memory itself is not cleared.
// Results are not held back: each is valid for the single cycle done is high.
module bounded_deque_with_search #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dqs_pkg::MODE_W-1:0]    mode,
	input  logic signed [dqs_pkg::DATA_W-1:0] value,
	output logic                          done,
	output logic [dqs_pkg::STATUS_W-1:0]  status,
	output logic                          found,
	output logic [CW-1:0]                 count
);
	import dqs_pkg::*;
	`include "bounded_deque_with_search_assert.svh"

	localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t            state_q, state_d;
	logic [AW-1:0]     head_q, tail_q, ptr_q;
	logic [CW-1:0]     count_q, idx_q;
	logic [DATA_W-1:0] key_q;
	logic              done_q, found_q;
	logic [STATUS_W-1:0] status_q;
	logic              cmp_vld_s1, last_s1;

	logic              accept, full, empty, issue, match, finish;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] rdata;

	// Ring position arithmetic that also holds for a depth that is not a power of two.
	function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
		return (p == LAST_POS) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] pos_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST_POS : p - AW'(1);
	endfunction

	assign accept = start && !busy;
	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign busy   = (state_q != S_IDLE);

	// Pushes write straight into the ring on the accepting cycle.
	assign we    = accept && !full && ((mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK));
	assign waddr = (mode == MODE_PUSH_FRONT) ? pos_dec(head_q) : tail_q;

	// Search compare stage: the entry read last cycle against the key.
	assign match  = (rdata == key_q);
	assign finish = (state_q == S_SEARCH) && cmp_vld_s1 && (match || last_s1);
	assign issue  = (state_q == S_SEARCH) && (idx_q < count_q) && !finish;

	dqs_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (mode == MODE_SEARCH) && !empty) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			done_q     <= 1'b0;
			if (accept) begin
				done_q <= !((mode == MODE_SEARCH) && !empty);
				case (mode)
					MODE_PUSH_FRONT: begin
						if (!full) begin
							head_q  <= pos_dec(head_q);
							count_q <= count_q + CW'(1);
						end
					end
					MODE_PUSH_BACK: begin
						if (!full) begin
							tail_q  <= pos_inc(tail_q);
							count_q <= count_q + CW'(1);
						end
					end
					MODE_POP_FRONT: begin
						if (!empty) begin
							head_q  <= pos_inc(head_q);
							count_q <= count_q - CW'(1);
						end
					end
					MODE_POP_BACK: begin
						if (!empty) begin
							tail_q  <= pos_dec(tail_q);
							count_q <= count_q - CW'(1);
						end
					end
					default: ;
				endcase
			end else if (finish) begin
				done_q <= 1'b1;
			end
		end
	end

	// Result payload, search key and scan position.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= value;
			ptr_q    <= head_q;
			idx_q    <= '0;
			found_q  <= 1'b0;
			status_q <= STAT_OK;
			if (((mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK)) && full) begin
				status_q <= STAT_FULL;
			end else if (((mode == MODE_POP_FRONT) || (mode == MODE_POP_BACK)) && empty) begin
				status_q <= STAT_EMPTY;
			end
		end else begin
			if (issue) begin
				ptr_q <= pos_inc(ptr_q);
				idx_q <= idx_q + CW'(1);
			end
			if (finish) begin
				found_q <= match;
			end
		end
		last_s1 <= (idx_q == count_q - CW'(1));
	end

	assign done   = done_q;
	assign status = status_q;
	assign found  = found_q;
	assign count  = count_q;

	`DQS_ASSERT_NEXT(a_quick_op_done, accept && (mode != MODE_SEARCH), done, "result missing")
	`DQS_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while still busy")
	`DQS_ASSERT_NOW(a_found_ok, done && found, status == STAT_OK, "found with refusal")
	`DQS_ASSERT_NOW(a_cmp_in_search, cmp_vld_s1, state_q == S_SEARCH, "compare outside search")

endmodule

// ===== rtl/dqs_ram.sv =====
`timescale 1ns / 1ps
module dqs_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [dqs_pkg::DATA_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [dqs_pkg::DATA_W-1:0]  rdata
);
	import dqs_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import dqs_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [CNT_W-1:0]    count;
	} deque_result_t;

	typedef struct {
		logic [MODE_W-1:0] op;
		logic [DATA_W-1:0] operand;
		bit                typed;
		deque_result_t     want;
	} stim_row_t;

	typedef enum int {
		SEG_FILL,
		SEG_DRAIN,
		SEG_MIXED
	} segment_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [MODE_W-1:0]          mode;
	logic signed [DATA_W-1:0]   value;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic                       found;
	logic [CNT_W-1:0]           count;

	// Shadow copy of the deque, updated as each command is transferred.
	logic [DATA_W-1:0] ring_mem [DEPTH];
	logic [PTR_W-1:0]  front_ptr;
	logic [CNT_W-1:0]  live_count;

	deque_result_t expected_results [$];
	deque_result_t oldest_expected;
	stim_row_t     directed_rows [$];

	int unsigned error_count = 0;
	int unsigned cmds_sent = 0;
	int unsigned results_seen = 0;
	int unsigned search_hits = 0;
	int unsigned full_refusals = 0;
	int unsigned empty_refusals = 0;
	int unsigned cycle_count = 0;
	bit          burst = 0;

	bounded_deque_with_search #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.done(done),
		.status(status),
		.found(found),
		.count(count)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Computes the result of one command and advances the shadow deque.
	function automatic deque_result_t apply_deque_op(logic [MODE_W-1:0] op,
			logic [DATA_W-1:0] operand);
		deque_result_t res;
		logic [PTR_W-1:0] slot;
		res = '0;
		res.status = STAT_OK;
		case (op)
			MODE_PUSH_FRONT: begin
				if (live_count >= DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					front_ptr = front_ptr - 1'b1;
					ring_mem[front_ptr] = operand;
					live_count = live_count + 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				if (live_count >= DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					slot = front_ptr + PTR_W'(live_count);
					ring_mem[slot] = operand;
					live_count = live_count + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (live_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					front_ptr = front_ptr + 1'b1;
					live_count = live_count - 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (live_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					live_count = live_count - 1'b1;
				end
			end
			MODE_SEARCH: begin
				for (int i = 0; i < live_count; i++) begin
					slot = front_ptr + PTR_W'(i);
					if (ring_mem[slot] == operand)
						res.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.count = live_count;
		return res;
	endfunction

	// Idle length before a command: mostly back to back, a few long pauses.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Data values lean toward extremes and a small set that repeats often.
	function automatic logic [DATA_W-1:0] pick_operand();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end else if (r < 30) begin
			return DATA_W'($urandom_range(0, 7));
		end
		return $urandom;
	endfunction

	// Presents one command and waits for its transfer, then records the expectation.
	task automatic send_cmd(logic [MODE_W-1:0] op, logic [DATA_W-1:0] operand,
			bit typed, deque_result_t want);
		int unsigned gap;
		deque_result_t predicted;
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		mode = op;
		value = operand;
		do @(posedge clk); while (busy);
		predicted = apply_deque_op(op, operand);
		expected_results.push_back(typed ? want : predicted);
		cmds_sent++;
	endtask

	// One random command with the given push and pop weights; the rest are searches or unused codes.
	task automatic send_random(int unsigned push_pct, int unsigned pop_pct);
		int unsigned r;
		logic [MODE_W-1:0] op;
		logic [DATA_W-1:0] operand;
		logic [PTR_W-1:0] slot;
		r = $urandom_range(0, 99);
		operand = pick_operand();
		if (r < push_pct) begin
			op = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
		end else if (r < push_pct + pop_pct) begin
			op = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
		end else if ($urandom_range(0, 19) == 0) begin
			op = MODE_W'($urandom_range(MODE_SEARCH + 1, {MODE_W{1'b1}}));
		end else begin
			op = MODE_SEARCH;
			// On a non-empty deque, half of the searches look for a value that is currently stored.
			if (live_count != 0 && $urandom_range(0, 1)) begin
				slot = front_ptr + PTR_W'($urandom_range(0, live_count - 1));
				operand = ring_mem[slot];
			end
		end
		send_cmd(op, operand, 1'b0, '0);
	endtask

	task automatic add_row(logic [MODE_W-1:0] op, logic [DATA_W-1:0] operand, bit typed,
			logic [STATUS_W-1:0] st, logic fnd, int unsigned cnt);
		stim_row_t row;
		row.op = op;
		row.operand = operand;
		row.typed = typed;
		row.want.status = st;
		row.want.found = fnd;
		row.want.count = CNT_W'(cnt);
		directed_rows.push_back(row);
	endtask

	// Random traffic in segments: fill to overflow, drain to underflow, or mixed.
	task automatic run_random_traffic();
		int unsigned target;
		int unsigned seg_index;
		segment_t seg;
		target = cmds_sent + RANDOM_ITEMS;
		seg_index = 0;
		while (cmds_sent < target) begin
			if (seg_index == 0)
				seg = SEG_FILL;
			else if (seg_index == 1)
				seg = SEG_DRAIN;
			else
				seg = segment_t'($urandom_range(0, 2));
			seg_index++;
			burst = ($urandom_range(0, 3) == 0);
			case (seg)
				SEG_FILL: begin
					while (live_count < DEPTH)
						send_random(80, 5);
					repeat ($urandom_range(1, 3)) send_random(100, 0);
					send_random(0, 0);
				end
				SEG_DRAIN: begin
					while (live_count != 0)
						send_random(5, 80);
					repeat ($urandom_range(1, 3)) send_random(0, 100);
					send_random(0, 0);
				end
				default: begin
					repeat ($urandom_range(20, 60)) send_random(40, 35);
				end
			endcase
		end
		burst = 1'b0;
	endtask

	// Checks each result strobe against the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: status=%0d found=%0d count=%0d",
					$time, status, found, count);
				error_count++;
			end else begin
				oldest_expected = expected_results.pop_front();
				results_seen++;
				if (oldest_expected.found)
					search_hits++;
				if (oldest_expected.status == STAT_FULL)
					full_refusals++;
				if (oldest_expected.status == STAT_EMPTY)
					empty_refusals++;
				if (status !== oldest_expected.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, oldest_expected.status, status);
					error_count++;
				end
				if (found !== oldest_expected.found) begin
					$display("%0t: found expected %0d actual %0d",
						$time, oldest_expected.found, found);
					error_count++;
				end
				if (count !== oldest_expected.count) begin
					$display("%0t: count expected %0d actual %0d",
						$time, oldest_expected.count, count);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("bounded_deque_with_search: mismatch");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random traffic, drain.
	initial begin
		start = 1'b0;
		mode = MODE_PUSH_FRONT;
		value = '0;
		arst_n = 1'b0;
		front_ptr = '0;
		live_count = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Empty store, extreme values, unused codes and a pop that empties the store.
		add_row(MODE_POP_FRONT,  32'h0000_0000, 1'b1, STAT_EMPTY, 1'b0, 0);
		add_row(MODE_POP_BACK,   32'hFFFF_FFFF, 1'b1, STAT_EMPTY, 1'b0, 0);
		add_row(MODE_SEARCH,     32'h0000_0000, 1'b1, STAT_OK,    1'b0, 0);
		add_row(MODE_PUSH_FRONT, 32'h8000_0000, 1'b1, STAT_OK,    1'b0, 1);
		add_row(MODE_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, STAT_OK,    1'b0, 2);
		add_row(MODE_SEARCH,     32'h8000_0000, 1'b1, STAT_OK,    1'b1, 2);
		add_row(MODE_SEARCH,     32'h7FFF_FFFF, 1'b1, STAT_OK,    1'b1, 2);
		add_row(MODE_SEARCH,     32'h0000_0000, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_SEARCH,     32'hFFFF_FFFF, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, STAT_OK,    1'b0, 3);
		add_row(MODE_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, STAT_OK,    1'b0, 4);
		add_row(MODE_SEARCH,     32'h0000_0000, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_W'(MODE_SEARCH + 1), 32'h1234_5678, 1'b1, STAT_OK, 1'b0, 4);
		add_row(MODE_W'(MODE_SEARCH + 2), 32'h0000_0000, 1'b1, STAT_OK, 1'b0, 4);
		add_row({MODE_W{1'b1}},  32'hFFFF_FFFF, 1'b1, STAT_OK,    1'b0, 4);
		add_row(MODE_POP_FRONT,  32'h5555_5555, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_SEARCH,     32'h0000_0000, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_POP_BACK,   32'hAAAA_AAAA, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_SEARCH,     32'hFFFF_FFFF, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_POP_FRONT,  32'h0000_0000, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_POP_BACK,   32'h0000_0000, 1'b1, STAT_OK,    1'b0, 0);
		add_row(MODE_POP_BACK,   32'h0000_0000, 1'b1, STAT_EMPTY, 1'b0, 0);
		add_row(MODE_PUSH_BACK,  32'h1234_5678, 1'b1, STAT_OK,    1'b0, 1);
		add_row(MODE_PUSH_FRONT, 32'hA5A5_A5A5, 1'b1, STAT_OK,    1'b0, 2);
		add_row(MODE_SEARCH,     32'h1234_5678, 1'b1, STAT_OK,    1'b1, 2);
		add_row(MODE_POP_BACK,   32'h0000_0000, 1'b0, STAT_OK,    1'b0, 0);
		add_row(MODE_POP_FRONT,  32'h0000_0000, 1'b0, STAT_OK,    1'b0, 0);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].op, directed_rows[i].operand,
				directed_rows[i].typed, directed_rows[i].want);

		run_random_traffic();

		@(negedge clk);
		start = 1'b0;

		// Let every outstanding result arrive, then watch for strays.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("Ran %0d commands and checked %0d results: %0d search hits,", cmds_sent,
			results_seen, search_hits);
		$display("%0d pushes refused as full and %0d pops refused as empty.",
			full_refusals, empty_refusals);
		if (error_count == 0) begin
			$display("bounded_deque_with_search: match");
		end else begin
			$display("bounded_deque_with_search: mismatch");
		end
		$finish;
	end

endmodule

// ===== bounded_deque_with_search.f =====
+incdir+rtl
rtl/dqs_pkg.sv
rtl/dqs_ram.sv
rtl/bounded_deque_with_search.sv
verif/tb_top.sv
